/* design/ray_disk_intersect_top_assert.svh */
// Assertion macros for the ray versus disk intersection block.
// Used by the port checker; depends only on clk and arst_n in the including scope.
`ifndef RAY_DISK_INTERSECT_TOP_ASSERT_SVH
`define RAY_DISK_INTERSECT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ray_disk_intersect assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ray_disk_intersect assertion failed");

`endif

/* design/rdi_pkg.sv */
// Shared types and constants for the ray versus disk intersection block.
// No dependencies; used by rdi_div and ray_disk_intersect_top.
`timescale 1ns / 1ps
`default_nettype none

package rdi_pkg;

	// Register indexes on the write port.
	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_NORMAL_X = 3'd3;
	localparam logic [2:0] REG_NORMAL_Y = 3'd4;
	localparam logic [2:0] REG_NORMAL_Z = 3'd5;
	localparam logic [2:0] REG_RADIUS   = 3'd6;

	// Reset values of the disk registers.
	localparam logic signed [31:0] NORMAL_Z_RST = 32'sd65536;
	localparam logic [30:0]        RADIUS_RST   = 31'd65536;

	// Divider geometry: |b| << 16 fits in 81 bits, |a| in 64 bits,
	// and a quotient that passes the saturation check has 31 bits.
	localparam int NUM_W     = 81;
	localparam int DEN_W     = 64;
	localparam int DIV_STEPS = 31;
	localparam int CMP_W     = DEN_W + DIV_STEPS + 1;

	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

	// One ray as it travels down the pipeline.
	typedef struct packed {
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] oz;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dz;
		logic [31:0] tl;
		logic [31:0] tu;
	} ray_t;

	// Side information that rides along with the divider.
	typedef struct packed {
		ray_t ray;
		logic neg;
		logic sat;
		logic azero;
	} div_meta_t;

endpackage

`default_nettype wire

/* design/ray_disk_intersect_top.sv */
// Top level of the ray versus disk intersection pipeline, Q16.16 fixed point.
// Depends on rdi_pkg and rdi_div.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    origin_x/y/z, dir_x/y/z, t_lower, t_upper
//   output   out_valid / out_ready  hit, hit_distance, point_x/y/z
//   config   wr_en                  wr_index, wr_data
//
// One ray is taken per cycle while the output is not stalled.
// The depth is set by the 31-stage divider for t plus eleven arithmetic stages.
// A stalled output freezes the whole pipeline through one shared enable;
// in_ready follows that enable, so nothing is dropped or repeated.
// Reset clears the valid bits and loads the disk registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ray_disk_intersect_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [31:0] origin_z,
	input  wire logic signed [31:0] dir_x,
	input  wire logic signed [31:0] dir_y,
	input  wire logic signed [31:0] dir_z,
	input  wire logic signed [31:0] t_lower,
	input  wire logic signed [31:0] t_upper,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic signed [31:0]      hit_distance,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic signed [31:0]      point_z,
	input  wire logic               wr_en,
	input  wire logic [2:0]         wr_index,
	input  wire logic [31:0]        wr_data
);

	logic en;

	// Disk registers.
	logic signed [31:0] center_q [3];
	logic signed [31:0] normal_q [3];
	logic [30:0]        radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= rdi_pkg::NORMAL_Z_RST;
			radius_q    <= rdi_pkg::RADIUS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				rdi_pkg::REG_CENTER_X: center_q[0] <= wr_data;
				rdi_pkg::REG_CENTER_Y: center_q[1] <= wr_data;
				rdi_pkg::REG_CENTER_Z: center_q[2] <= wr_data;
				rdi_pkg::REG_NORMAL_X: normal_q[0] <= wr_data;
				rdi_pkg::REG_NORMAL_Y: normal_q[1] <= wr_data;
				rdi_pkg::REG_NORMAL_Z: normal_q[2] <= wr_data;
				rdi_pkg::REG_RADIUS:   radius_q    <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	// Shared advance enable: the pipeline moves unless a finished beat is held.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	logic div_vld;

	assign en       = !vld_s11 || out_ready;
	assign in_ready = en;

	rdi_pkg::ray_t ray_in;
	assign ray_in = '{ox: origin_x, oy: origin_y, oz: origin_z,
		dx: dir_x, dy: dir_y, dz: dir_z, tl: t_lower, tu: t_upper};

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= div_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Stage 1: products n*d and differences c - o.
	rdi_pkg::ray_t      ray_s1;
	logic signed [63:0] pnd_s1  [3];
	logic signed [32:0] diff_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1     <= ray_in;
			pnd_s1[0]  <= normal_q[0] * dir_x;
			pnd_s1[1]  <= normal_q[1] * dir_y;
			pnd_s1[2]  <= normal_q[2] * dir_z;
			diff_s1[0] <= 33'(center_q[0]) - 33'(origin_x);
			diff_s1[1] <= 33'(center_q[1]) - 33'(origin_y);
			diff_s1[2] <= 33'(center_q[2]) - 33'(origin_z);
		end
	end

	// Stage 2: a = sum n*d, and products n*(c - o).
	rdi_pkg::ray_t      ray_s2;
	logic signed [65:0] suma_s2;
	logic signed [64:0] pnb_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2    <= ray_s1;
			suma_s2   <= 66'(pnd_s1[0]) + 66'(pnd_s1[1]) + 66'(pnd_s1[2]);
			pnb_s2[0] <= 65'(normal_q[0]) * 65'(diff_s1[0]);
			pnb_s2[1] <= 65'(normal_q[1]) * 65'(diff_s1[1]);
			pnb_s2[2] <= 65'(normal_q[2]) * 65'(diff_s1[2]);
		end
	end

	// Stage 3: b = sum n*(c - o); magnitude and sign of a.
	rdi_pkg::ray_t                 ray_s3;
	logic signed [66:0]            sumb_s3;
	logic [rdi_pkg::DEN_W-1:0]     absa_s3;
	logic                          na_s3;
	logic                          azero_s3;
	logic [65:0]                   absa_w;

	assign absa_w = suma_s2[65] ? 66'(-suma_s2) : 66'(suma_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s3   <= ray_s2;
			sumb_s3  <= 67'(pnb_s2[0]) + 67'(pnb_s2[1]) + 67'(pnb_s2[2]);
			absa_s3  <= absa_w[rdi_pkg::DEN_W-1:0];
			na_s3    <= suma_s2[65];
			azero_s3 <= (suma_s2 == '0);
		end
	end

	// Stage 4: scaled magnitude of b as the dividend; sign of t.
	rdi_pkg::ray_t                 ray_s4;
	logic [rdi_pkg::NUM_W-1:0]     num_s4;
	logic [rdi_pkg::DEN_W-1:0]     den_s4;
	logic                          neg_s4;
	logic                          azero_s4;
	logic [66:0]                   absb_w;

	assign absb_w = sumb_s3[66] ? 67'(-sumb_s3) : 67'(sumb_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4   <= ray_s3;
			num_s4   <= {absb_w[64:0], 16'd0};
			den_s4   <= absa_s3;
			neg_s4   <= na_s3 ^ sumb_s3[66];
			azero_s4 <= azero_s3;
		end
	end

	// Stage 5: the quotient saturates when the dividend reaches 2^31 times |a|.
	logic [rdi_pkg::NUM_W-1:0]     num_s5;
	logic [rdi_pkg::DEN_W-1:0]     den_s5;
	rdi_pkg::div_meta_t            meta_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5        <= num_s4;
			den_s5        <= den_s4;
			meta_s5.ray   <= ray_s4;
			meta_s5.neg   <= neg_s4;
			meta_s5.azero <= azero_s4;
			meta_s5.sat   <= {{(rdi_pkg::CMP_W-rdi_pkg::NUM_W){1'b0}}, num_s4}
				>= {1'b0, den_s4, {rdi_pkg::DIV_STEPS{1'b0}}};
		end
	end

	// Divider for the magnitude of t.
	logic [rdi_pkg::DIV_STEPS-1:0] div_quo;
	rdi_pkg::div_meta_t            div_meta;

	rdi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_meta  (meta_s5),
		.out_vld  (div_vld),
		.out_quo  (div_quo),
		.out_meta (div_meta)
	);

	// Stage 6: signed, clamped t and the strict range test.
	rdi_pkg::ray_t      ray_s6;
	logic signed [31:0] t_s6;
	logic               ok_s6;
	logic signed [31:0] t_w;
	logic signed [31:0] q_w;

	assign q_w = {1'b0, div_quo};

	always_comb begin
		priority if (div_meta.sat) begin
			t_w = div_meta.neg ? rdi_pkg::T_MIN : rdi_pkg::T_MAX;
		end else if (div_meta.neg) begin
			t_w = -q_w;
		end else begin
			t_w = q_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s6 <= div_meta.ray;
			t_s6   <= t_w;
			ok_s6  <= !div_meta.azero && (t_w > $signed(div_meta.ray.tl))
				&& (t_w < $signed(div_meta.ray.tu));
		end
	end

	// Stage 7: products t*d.
	rdi_pkg::ray_t      ray_s7;
	logic signed [31:0] t_s7;
	logic               ok_s7;
	logic signed [63:0] ptd_s7 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s7    <= ray_s6;
			t_s7      <= t_s6;
			ok_s7     <= ok_s6;
			ptd_s7[0] <= t_s6 * $signed(ray_s6.dx);
			ptd_s7[1] <= t_s6 * $signed(ray_s6.dy);
			ptd_s7[2] <= t_s6 * $signed(ray_s6.dz);
		end
	end

	// Stage 8: hit point p = o + floor(t*d / 2^16), kept exact.
	logic signed [31:0] t_s8;
	logic               ok_s8;
	logic signed [48:0] p_s8 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s8    <= t_s7;
			ok_s8   <= ok_s7;
			p_s8[0] <= 49'($signed(ray_s7.ox)) + 49'(ptd_s7[0] >>> 16);
			p_s8[1] <= 49'($signed(ray_s7.oy)) + 49'(ptd_s7[1] >>> 16);
			p_s8[2] <= 49'($signed(ray_s7.oz)) + 49'(ptd_s7[2] >>> 16);
		end
	end

	// Stage 9: distance from the center per axis, and saturated outputs.
	logic signed [31:0] t_s9;
	logic               ok_s9;
	logic               big_s9;
	logic [30:0]        m_s9   [3];
	logic signed [31:0] pout_s9 [3];
	logic signed [49:0] v_w    [3];
	logic [49:0]        m_w    [3];
	logic signed [31:0] psat_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v_w[i] = 50'(p_s8[i]) - 50'(center_q[i]);
			m_w[i] = v_w[i][49] ? 50'(-v_w[i]) : 50'(v_w[i]);
			if (p_s8[i] > 49'(rdi_pkg::T_MAX)) begin
				psat_w[i] = rdi_pkg::T_MAX;
			end else if (p_s8[i] < 49'(rdi_pkg::T_MIN)) begin
				psat_w[i] = rdi_pkg::T_MIN;
			end else begin
				psat_w[i] = p_s8[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s9   <= t_s8;
			ok_s9  <= ok_s8;
			big_s9 <= (m_w[0] >= {19'd0, radius_q}) || (m_w[1] >= {19'd0, radius_q})
				|| (m_w[2] >= {19'd0, radius_q});
			for (int i = 0; i < 3; i++) begin
				m_s9[i]    <= m_w[i][30:0];
				pout_s9[i] <= psat_w[i];
			end
		end
	end

	// Stage 10: squares of the distances and of the radius.
	logic signed [31:0] t_s10;
	logic               ok_s10;
	logic               big_s10;
	logic [61:0]        sq_s10  [3];
	logic [61:0]        rr_s10;
	logic signed [31:0] pout_s10 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s10   <= t_s9;
			ok_s10  <= ok_s9;
			big_s10 <= big_s9;
			rr_s10  <= 62'(radius_q) * 62'(radius_q);
			for (int i = 0; i < 3; i++) begin
				sq_s10[i]   <= 62'(m_s9[i]) * 62'(m_s9[i]);
				pout_s10[i] <= pout_s9[i];
			end
		end
	end

	// Stage 11: radius test and the output register; a miss reports zeros.
	logic               hit_s11;
	logic signed [31:0] dist_s11;
	logic signed [31:0] px_s11, py_s11, pz_s11;
	logic [63:0]        dsum_w;
	logic               hit_w;

	assign dsum_w = 64'(sq_s10[0]) + 64'(sq_s10[1]) + 64'(sq_s10[2]);
	assign hit_w  = ok_s10 && !big_s10 && (dsum_w < 64'(rr_s10));

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s11  <= hit_w;
			dist_s11 <= hit_w ? t_s10 : '0;
			px_s11   <= hit_w ? pout_s10[0] : '0;
			py_s11   <= hit_w ? pout_s10[1] : '0;
			pz_s11   <= hit_w ? pout_s10[2] : '0;
		end
	end

	assign out_valid    = vld_s11;
	assign hit          = hit_s11;
	assign hit_distance = dist_s11;
	assign point_x      = px_s11;
	assign point_y      = py_s11;
	assign point_z      = pz_s11;

endmodule

`default_nettype wire

/* design/rdi_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rdi_pkg for widths and the side information type.
`timescale 1ns / 1ps
`default_nettype none

module rdi_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_vld,
	input  wire logic [rdi_pkg::NUM_W-1:0]     in_num,
	input  wire logic [rdi_pkg::DEN_W-1:0]     in_den,
	input  wire rdi_pkg::div_meta_t            in_meta,
	output logic                               out_vld,
	output logic [rdi_pkg::DIV_STEPS-1:0]      out_quo,
	output rdi_pkg::div_meta_t                 out_meta
);

	// Registered outputs of each step.
	logic                            vld_s  [rdi_pkg::DIV_STEPS];
	logic [rdi_pkg::NUM_W-1:0]       rem_s  [rdi_pkg::DIV_STEPS];
	logic [rdi_pkg::DEN_W-1:0]       den_s  [rdi_pkg::DIV_STEPS];
	logic [rdi_pkg::DIV_STEPS-1:0]   quo_s  [rdi_pkg::DIV_STEPS];
	rdi_pkg::div_meta_t              meta_s [rdi_pkg::DIV_STEPS];

	for (genvar j = 0; j < rdi_pkg::DIV_STEPS; j++) begin : g_step
		localparam int K = rdi_pkg::DIV_STEPS - 1 - j;

		logic                            vld_c;
		logic [rdi_pkg::NUM_W-1:0]       rem_c;
		logic [rdi_pkg::DEN_W-1:0]       den_c;
		logic [rdi_pkg::DIV_STEPS-1:0]   quo_c;
		rdi_pkg::div_meta_t              meta_c;
		logic [rdi_pkg::CMP_W-1:0]       shd;
		logic [rdi_pkg::CMP_W-1:0]       rem_w;
		logic                            ge;

		// Take the previous step, or the divider inputs for the first one.
		if (j == 0) begin : g_first
			assign vld_c  = in_vld;
			assign rem_c  = in_num;
			assign den_c  = in_den;
			assign quo_c  = '0;
			assign meta_c = in_meta;
		end else begin : g_next
			assign vld_c  = vld_s[j-1];
			assign rem_c  = rem_s[j-1];
			assign den_c  = den_s[j-1];
			assign quo_c  = quo_s[j-1];
			assign meta_c = meta_s[j-1];
		end

		// Trial subtraction of the divisor shifted to this bit weight.
		assign shd   = {{(rdi_pkg::CMP_W-rdi_pkg::DEN_W){1'b0}}, den_c} << K;
		assign rem_w = {{(rdi_pkg::CMP_W-rdi_pkg::NUM_W){1'b0}}, rem_c};
		assign ge    = (rem_w >= shd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? rem_w[rdi_pkg::NUM_W-1:0] - shd[rdi_pkg::NUM_W-1:0] : rem_c;
				den_s[j]  <= den_c;
				quo_s[j]  <= {quo_c[rdi_pkg::DIV_STEPS-2:0], ge};
				meta_s[j] <= meta_c;
			end
		end
	end

	assign out_vld  = vld_s[rdi_pkg::DIV_STEPS-1];
	assign out_quo  = quo_s[rdi_pkg::DIV_STEPS-1];
	assign out_meta = meta_s[rdi_pkg::DIV_STEPS-1];

	// The final remainder is not needed downstream; only the quotient leaves.

endmodule

`default_nettype wire

/* design/rdi_check.sv */
// Port-level checker for ray_disk_intersect_top, attached by bind.
// Depends on ray_disk_intersect_top_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "ray_disk_intersect_top_assert.svh"

module rdi_check (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               hit,
	input wire logic signed [31:0] hit_distance,
	input wire logic signed [31:0] point_x,
	input wire logic signed [31:0] point_y,
	input wire logic signed [31:0] point_z
);

	// A held result beat keeps its hit flag, distance and point_x until it is taken.
	`RDI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(hit_distance) && $stable(point_x))

	// Whenever the output side can move, in_ready is high.
	`RDI_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready)

	// A miss carries an all-zero payload.
	`RDI_ASSERT_NOW(a_miss_zero, out_valid && !hit, hit_distance == 32'sd0 && point_x == 32'sd0 && point_y == 32'sd0 && point_z == 32'sd0)

	// A clamped t never passes the strict bound test.
	`RDI_ASSERT_NOW(a_hit_unclamped, out_valid && hit, hit_distance != 32'sh7FFF_FFFF && hit_distance != 32'sh8000_0000)

endmodule

bind ray_disk_intersect_top rdi_check u_rdi_check (.*);

`default_nettype wire
